// ===== src/longest_decreasing_subsequence_assert.svh =====
// ---------------------------------------------------------------------------
// Longest decreasing subsequence: assertion macros
// Concurrent check macros clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef LONGEST_DECREASING_SUBSEQUENCE_ASSERT_SVH
`define LONGEST_DECREASING_SUBSEQUENCE_ASSERT_SVH

`ifndef SYNTH

`define LDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define LDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LDS_ASSERT_SAME(lbl, ante, cons, msg)

`define LDS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/lds_pkg.sv =====
// ---------------------------------------------------------------------------
// Longest decreasing subsequence: package
// Operation and status codes, controller states and the command and status
// groups between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package lds_pkg;

  localparam int OP_W   = 2;
  localparam int VIN_W  = 32;
  localparam int IDX_W  = 10;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 11;
  localparam int PIDX_W = 10;
  localparam int ELEM_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_FINISH = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_CMP,
    S_PLACE,
    S_FTOP,
    S_FREAD,
    S_FWRITE,
    S_RWAIT
  } state_e;

  typedef struct packed {
    logic load;
    logic srch_upd;
    logic pile_rd_prev;
    logic pile_rd_last;
    logic place;
    logic fcur_ld;
    logic fwrite;
    logic seq_set;
    logic clear;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic piles_zero;
    logic idx_ok;
    logic lo_lt_hi;
    logic pred_zero;
    logic k_one;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/lds_ram.sv =====
// ---------------------------------------------------------------------------
// Longest decreasing subsequence: generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module lds_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/lds_ctrl.sv =====
// ---------------------------------------------------------------------------
// Longest decreasing subsequence: controller
// Sequences the binary search, placement, chain walk and read-back steps.
// ---------------------------------------------------------------------------
`default_nettype none

module lds_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire lds_pkg::dp_stat_t stat_i,
  output lds_pkg::ctrl_cmd_t     cmd_o
);

  lds_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lds_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      lds_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = lds_pkg::S_DISPATCH;
        end
      end
      lds_pkg::S_DISPATCH: begin
        case (stat_i.op)
          lds_pkg::OP_PUSH: begin
            if (stat_i.full) begin
              cmd_o.finish = 1'b1;
              state_d      = lds_pkg::S_IDLE;
            end else begin
              state_d = lds_pkg::S_SEARCH;
            end
          end
          lds_pkg::OP_FINISH: begin
            if (stat_i.piles_zero) begin
              cmd_o.seq_set = 1'b1;
              cmd_o.finish  = 1'b1;
              state_d       = lds_pkg::S_IDLE;
            end else begin
              cmd_o.pile_rd_last = 1'b1;
              state_d            = lds_pkg::S_FTOP;
            end
          end
          lds_pkg::OP_READ: begin
            if (stat_i.idx_ok) begin
              state_d = lds_pkg::S_RWAIT;
            end else begin
              cmd_o.finish = 1'b1;
              state_d      = lds_pkg::S_IDLE;
            end
          end
          lds_pkg::OP_CLEAR: begin
            cmd_o.clear  = 1'b1;
            cmd_o.finish = 1'b1;
            state_d      = lds_pkg::S_IDLE;
          end
          default: begin
            state_d = lds_pkg::S_IDLE;
          end
        endcase
      end
      lds_pkg::S_SEARCH: begin
        if (stat_i.lo_lt_hi) begin
          state_d = lds_pkg::S_CMP;
        end else begin
          cmd_o.pile_rd_prev = 1'b1;
          state_d            = lds_pkg::S_PLACE;
        end
      end
      lds_pkg::S_CMP: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = lds_pkg::S_SEARCH;
      end
      lds_pkg::S_PLACE: begin
        cmd_o.place  = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = lds_pkg::S_IDLE;
      end
      lds_pkg::S_FTOP: begin
        cmd_o.fcur_ld = 1'b1;
        state_d       = lds_pkg::S_FREAD;
      end
      lds_pkg::S_FREAD: begin
        state_d = lds_pkg::S_FWRITE;
      end
      lds_pkg::S_FWRITE: begin
        cmd_o.fwrite = 1'b1;
        if (stat_i.pred_zero || stat_i.k_one) begin
          cmd_o.seq_set = 1'b1;
          cmd_o.finish  = 1'b1;
          state_d       = lds_pkg::S_IDLE;
        end else begin
          state_d = lds_pkg::S_FREAD;
        end
      end
      lds_pkg::S_RWAIT: begin
        cmd_o.finish = 1'b1;
        state_d      = lds_pkg::S_IDLE;
      end
      default: begin
        state_d = lds_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != lds_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== src/lds_dpath.sv =====
// ---------------------------------------------------------------------------
// Longest decreasing subsequence: datapath
// Pile, item and sequence memories, search bounds, counters and result beat.
// ---------------------------------------------------------------------------
`default_nettype none

module lds_dpath #(
  parameter int MAX_ITEMS  = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lds_pkg::ctrl_cmd_t            cmd_i,
  output lds_pkg::dp_stat_t                  stat_o,
  input  wire logic [lds_pkg::OP_W-1:0]      op_i,
  input  wire logic [lds_pkg::VIN_W-1:0]     value_i,
  input  wire logic [lds_pkg::IDX_W-1:0]     index_i,
  output logic      [lds_pkg::STAT_W-1:0]    status_o,
  output logic      [lds_pkg::LEN_W-1:0]     length_o,
  output logic      [lds_pkg::PIDX_W-1:0]    pile_index_o,
  output logic      [lds_pkg::ELEM_W-1:0]    element_o,
  output logic                               done_o
);

  localparam int IW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int VW    = VALUE_BITS;
  localparam int IdxW  = lds_pkg::IDX_W;
  localparam int CmpW  = (CW > IdxW) ? CW : IdxW;
  localparam int LenW  = lds_pkg::LEN_W;
  localparam int PIdxW = lds_pkg::PIDX_W;
  localparam int ElemW = lds_pkg::ELEM_W;
  localparam int PileW = VW + IW;
  localparam int ItemW = VW + CW;

  lds_pkg::op_e          op_q;
  logic [VW-1:0]         v_q;
  logic [IdxW-1:0]       idx_q;
  logic [CW-1:0]         lo_q, hi_q, k_q;
  logic [IW-1:0]         cur_q;
  logic [CW-1:0]         pile_count_q, pile_count_d;
  logic [CW-1:0]         item_count_q, seq_len_q;
  logic [lds_pkg::STAT_W-1:0] status_q, status_d;
  logic [LenW-1:0]       length_q;
  logic [PIdxW-1:0]      pidx_q, pidx_d;
  logic [ElemW-1:0]      elem_q, elem_d;
  logic                  done_q;

  logic [CW-1:0]         mid;
  logic                  full, idx_ok;
  logic [IW-1:0]         pile_raddr, seq_waddr, seq_raddr;
  logic [PileW-1:0]      pile_rdata;
  logic [ItemW-1:0]      item_rdata;
  logic [VW-1:0]         seq_rdata;
  logic [VW-1:0]         top_value, item_value;
  logic [IW-1:0]         top_item;
  logic [CW-1:0]         item_pred, new_pred;

  assign mid        = lo_q + ((hi_q - lo_q) >> 1);
  assign full       = (item_count_q >= CW'(MAX_ITEMS));
  assign idx_ok     = (CmpW'(idx_q) < CmpW'(seq_len_q));
  assign top_value  = pile_rdata[PileW-1:IW];
  assign top_item   = pile_rdata[IW-1:0];
  assign item_value = item_rdata[ItemW-1:CW];
  assign item_pred  = item_rdata[CW-1:0];
  assign new_pred   = (lo_q != '0) ? (CW'(top_item) + CW'(1)) : '0;
  assign seq_waddr  = IW'(k_q - CW'(1));
  assign seq_raddr  = IW'(idx_q);

  always_comb begin
    if (cmd_i.pile_rd_last) begin
      pile_raddr = IW'(pile_count_q - CW'(1));
    end else if (cmd_i.pile_rd_prev) begin
      pile_raddr = IW'(lo_q - CW'(1));
    end else begin
      pile_raddr = IW'(mid);
    end
  end

  lds_ram #(.Width(PileW), .Depth(MAX_ITEMS)) u_pile_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.place),
    .waddr_i (IW'(lo_q)),
    .wdata_i ({v_q, IW'(item_count_q)}),
    .raddr_i (pile_raddr),
    .rdata_o (pile_rdata)
  );

  lds_ram #(.Width(ItemW), .Depth(MAX_ITEMS)) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.place),
    .waddr_i (IW'(item_count_q)),
    .wdata_i ({v_q, new_pred}),
    .raddr_i (cur_q),
    .rdata_o (item_rdata)
  );

  lds_ram #(.Width(VW), .Depth(MAX_ITEMS)) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fwrite),
    .waddr_i (seq_waddr),
    .wdata_i (item_value),
    .raddr_i (seq_raddr),
    .rdata_o (seq_rdata)
  );

  always_comb begin
    pile_count_d = pile_count_q;
    if (cmd_i.clear) begin
      pile_count_d = '0;
    end else if (cmd_i.place && (lo_q == pile_count_q)) begin
      pile_count_d = pile_count_q + CW'(1);
    end
  end

  always_comb begin
    status_d = lds_pkg::STAT_OK;
    pidx_d   = '0;
    elem_d   = '0;
    case (op_q)
      lds_pkg::OP_PUSH: begin
        if (full) begin
          status_d = lds_pkg::STAT_FULL;
        end else begin
          pidx_d = PIdxW'(lo_q);
        end
      end
      lds_pkg::OP_READ: begin
        if (idx_ok) begin
          elem_d = ElemW'(seq_rdata);
        end else begin
          status_d = lds_pkg::STAT_RANGE;
        end
      end
      default: begin
        status_d = lds_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pile_count_q <= '0;
      item_count_q <= '0;
      seq_len_q    <= '0;
      done_q       <= 1'b0;
    end else begin
      pile_count_q <= pile_count_d;
      done_q       <= cmd_i.finish;
      if (cmd_i.clear) begin
        item_count_q <= '0;
      end else if (cmd_i.place) begin
        item_count_q <= item_count_q + CW'(1);
      end
      if (cmd_i.clear) begin
        seq_len_q <= '0;
      end else if (cmd_i.seq_set) begin
        seq_len_q <= pile_count_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= lds_pkg::op_e'(op_i);
      v_q   <= VW'(value_i);
      idx_q <= index_i;
      lo_q  <= '0;
      hi_q  <= pile_count_q;
    end
    if (cmd_i.srch_upd) begin
      if (top_value > v_q) begin
        lo_q <= mid + CW'(1);
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.fcur_ld) begin
      cur_q <= top_item;
      k_q   <= pile_count_q;
    end
    if (cmd_i.fwrite) begin
      cur_q <= IW'(item_pred - CW'(1));
      k_q   <= k_q - CW'(1);
    end
    if (cmd_i.finish) begin
      status_q <= status_d;
      length_q <= LenW'(pile_count_d);
      pidx_q   <= pidx_d;
      elem_q   <= elem_d;
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.full       = full;
  assign stat_o.piles_zero = (pile_count_q == '0);
  assign stat_o.idx_ok     = idx_ok;
  assign stat_o.lo_lt_hi   = (lo_q < hi_q);
  assign stat_o.pred_zero  = (item_pred == '0);
  assign stat_o.k_one      = (k_q == CW'(1));

  assign status_o     = status_q;
  assign length_o     = length_q;
  assign pile_index_o = pidx_q;
  assign element_o    = elem_q;
  assign done_o       = done_q;

endmodule

`default_nettype wire

// ===== src/longest_decreasing_subsequence.sv =====
// ---------------------------------------------------------------------------
// Longest decreasing subsequence
// Patience sorting over a stream of values: push, finish, read back, clear.
// ---------------------------------------------------------------------------
//  Channel   Handshake              Fields
//  command   start / busy           op_i, value_i, index_i
//  result    done_o (one cycle)     status_o, length_o, pile_index_o, element_o
//
//  A push runs a binary search over the pile tops, each step a read and a
//  compare on the pile memory, and then places the value. A finish does one
//  item memory read and one sequence write per element of the result. A read
//  fetches its element from the sequence memory, and a clear, an ignored push,
//  a failed read or a finish with no piles ends at dispatch.
//  Reset clears the counters at once. The result beat cannot be held off, and
//  a new command may be taken in the cycle in which done_o is high.
// ---------------------------------------------------------------------------
`default_nettype none

`include "longest_decreasing_subsequence_assert.svh"

module longest_decreasing_subsequence #(
  parameter int MAX_ITEMS  = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [lds_pkg::OP_W-1:0]      op_i,
  input  wire logic [lds_pkg::VIN_W-1:0]     value_i,
  input  wire logic [lds_pkg::IDX_W-1:0]     index_i,
  output logic                               done_o,
  output logic      [lds_pkg::STAT_W-1:0]    status_o,
  output logic      [lds_pkg::LEN_W-1:0]     length_o,
  output logic      [lds_pkg::PIDX_W-1:0]    pile_index_o,
  output logic      [lds_pkg::ELEM_W-1:0]    element_o
);

  lds_pkg::ctrl_cmd_t cmd;
  lds_pkg::dp_stat_t  stat;

  lds_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lds_dpath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (op_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .status_o     (status_o),
    .length_o     (length_o),
    .pile_index_o (pile_index_o),
    .element_o    (element_o),
    .done_o       (done_o)
  );

  `LDS_ASSERT_SAME(a_done_idle, done_o, !busy, "Result beat while busy.")
  `LDS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted command did not start.")
  `LDS_ASSERT_SAME(a_status_code, done_o, status_o <= lds_pkg::STAT_RANGE, "Undefined status.")
  `LDS_ASSERT_SAME(a_elem_ok, done_o && (element_o != '0), status_o == lds_pkg::STAT_OK, "Bad element.")

endmodule

`default_nettype wire
